// ===== src/ratio_list_combiner_unit_defines.svh =====
// ----------------------------------------------------------------------------
// ratio_list_combiner_unit_defines
// Assertion macros used by the ratio list combiner RTL.
// ----------------------------------------------------------------------------
`ifndef RATIO_LIST_COMBINER_UNIT_DEFINES_SVH
`define RATIO_LIST_COMBINER_UNIT_DEFINES_SVH

// pre in one cycle implies post in the next
`define RLC_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

// pre implies post in the same cycle
`define RLC_ASSERT_SAME(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

`endif

// ===== src/rlc_pkg.sv =====
// ----------------------------------------------------------------------------
// rlc_pkg
// Shared constants and types of the ratio list combiner.
// ----------------------------------------------------------------------------
`default_nettype none

package rlc_pkg;

    localparam int RATIO_FRAC_BITS_DEFAULT = 16;
    localparam int MODE_WIDTH = 3;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_NORMAL   = 3'd0,
        MODE_MAX      = 3'd1,
        MODE_MIN      = 3'd2,
        MODE_SUM      = 3'd3,
        MODE_ABS_DIFF = 3'd4,
        MODE_DIFF     = 3'd5,
        MODE_PRODUCT  = 3'd6
    } mode_t;

endpackage

`default_nettype wire

// ===== src/ratio_list_combiner_unit.sv =====
// A request that ends its list is staged in the input registers; its result is then
// registered onto m_*. One request per cycle unless a staged list end waits on a
// stalled m_*; folding the staged request into the running register (add, compare or
// one multiply) is combinational. Reset: synchronous, active low; clears the list
// state, both pipeline valids and sets the mode to normal. No clearing pass.
// ----------------------------------------------------------------------------
// ratio_list_combiner_unit
// Folds a stream of signed fixed-point ratios into one combined ratio per list.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ratio_list_combiner_unit_defines.svh"

module ratio_list_combiner_unit #(
    parameter int RATIO_FRAC_BITS = rlc_pkg::RATIO_FRAC_BITS_DEFAULT,
    localparam int W = RATIO_FRAC_BITS + 5
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rlc_pkg::MODE_WIDTH-1:0] cfg_composition_mode,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [W-1:0]           s_ratio,
    input  wire logic                          s_last,
    input  wire logic                          s_empty_req,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [W-1:0]                m_combined,
    output logic                               m_saturated
);

    localparam int F  = RATIO_FRAC_BITS;
    localparam int PW = 2 * W + 1;
    localparam int QW = PW - F;

    localparam logic signed [W-1:0]   RATIO_ONE = {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [W+1:0]   WIDE_MAX  = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0]   WIDE_MIN  = {3'b111, {(W-1){1'b0}}};
    localparam logic [PW-1:0]         HALF      = PW'(1) << (F - 1);
    localparam logic [QW-1:0]         LIMIT_NEG = QW'(1) << (W - 1);
    localparam logic [QW-1:0]         LIMIT_POS = LIMIT_NEG - QW'(1);

    rlc_pkg::mode_t           mode_reg;
    logic                     in_valid_reg;
    logic signed [W-1:0]      in_ratio_reg;
    logic                     in_last_reg;
    logic                     in_empty_reg;
    logic signed [W-1:0]      running_reg;
    logic                     first_reg;
    logic                     clip_reg;
    logic                     out_valid_reg;
    logic signed [W-1:0]      out_combined_reg;
    logic                     out_saturated_reg;

    logic                     emits;
    logic                     advance;
    logic                     s_accept;

    logic signed [W+1:0]      rx;
    logic signed [W+1:0]      vx;
    logic signed [W+1:0]      diff_w;
    logic signed [W+1:0]      wide_sel;
    logic signed [W-1:0]      base;
    logic signed [W-1:0]      fold_next;
    logic                     clip_step;
    logic                     clip_next;
    logic signed [W-1:0]      final_val;

    logic [W-1:0]             mag_a;
    logic [W-1:0]             mag_b;
    logic                     prod_neg;
    logic [2*W-1:0]           prod;
    logic [PW-1:0]            rounded;
    logic [QW-1:0]            quot;
    logic                     prod_clip;
    logic signed [W-1:0]      prod_val;

    // product: exact magnitude multiply, round half away from zero, saturate
    always_comb begin
        mag_a    = running_reg[W-1] ? W'(-running_reg) : W'(running_reg);
        mag_b    = in_ratio_reg[W-1] ? W'(-in_ratio_reg) : W'(in_ratio_reg);
        prod_neg = running_reg[W-1] ^ in_ratio_reg[W-1];
        prod     = mag_a * mag_b;
        rounded  = {1'b0, prod} + HALF;
        quot     = rounded[PW-1:F];
        prod_clip = prod_neg ? (quot > LIMIT_NEG) : (quot > LIMIT_POS);
        if (prod_clip) begin
            prod_val = prod_neg ? WIDE_MIN[W-1:0] : WIDE_MAX[W-1:0];
        end else begin
            prod_val = prod_neg ? -$signed(quot[W-1:0]) : $signed(quot[W-1:0]);
        end
    end

    always_comb begin
        rx       = {{2{in_ratio_reg[W-1]}}, in_ratio_reg};
        vx       = {{2{running_reg[W-1]}}, running_reg};
        diff_w   = rx - vx;
        base     = running_reg;
        wide_sel = rx;
        clip_step = 1'b0;
        case (mode_reg)
            rlc_pkg::MODE_MAX: begin
                base     = first_reg ? -RATIO_ONE : running_reg;
                wide_sel = (in_ratio_reg > base) ? rx : {{2{base[W-1]}}, base};
            end
            rlc_pkg::MODE_MIN: begin
                base     = first_reg ? RATIO_ONE : running_reg;
                wide_sel = (in_ratio_reg < base) ? rx : {{2{base[W-1]}}, base};
            end
            rlc_pkg::MODE_SUM: begin
                wide_sel = first_reg ? rx : rx + vx;
            end
            rlc_pkg::MODE_ABS_DIFF: begin
                wide_sel = first_reg ? rx : (diff_w[W+1] ? -diff_w : diff_w);
            end
            rlc_pkg::MODE_DIFF: begin
                wide_sel = first_reg ? rx : diff_w;
            end
            rlc_pkg::MODE_PRODUCT: begin
                wide_sel  = first_reg ? rx : {{2{prod_val[W-1]}}, prod_val};
                clip_step = !first_reg && prod_clip;
            end
            default: begin
                base = first_reg ? '0 : running_reg;
                if (!in_ratio_reg[W-1] && !base[W-1]) begin
                    wide_sel = {2'b00, (in_ratio_reg > base) ? in_ratio_reg : base};
                end else if (in_ratio_reg[W-1] && base[W-1]) begin
                    wide_sel = {2'b11, (in_ratio_reg < base) ? in_ratio_reg : base};
                end else begin
                    wide_sel = rx + {{2{base[W-1]}}, base};
                end
            end
        endcase

        if (wide_sel > WIDE_MAX) begin
            fold_next = WIDE_MAX[W-1:0];
            clip_step = 1'b1;
        end else if (wide_sel < WIDE_MIN) begin
            fold_next = WIDE_MIN[W-1:0];
            clip_step = 1'b1;
        end else begin
            fold_next = wide_sel[W-1:0];
        end
        clip_next = clip_reg | clip_step;

        final_val = fold_next;
        if (mode_reg != rlc_pkg::MODE_MAX && mode_reg != rlc_pkg::MODE_MIN &&
            mode_reg != rlc_pkg::MODE_SUM && mode_reg != rlc_pkg::MODE_ABS_DIFF &&
            mode_reg != rlc_pkg::MODE_DIFF && mode_reg != rlc_pkg::MODE_PRODUCT) begin
            if (fold_next > RATIO_ONE) begin
                final_val = RATIO_ONE;
            end else if (fold_next < -RATIO_ONE) begin
                final_val = -RATIO_ONE;
            end
        end
    end

    assign emits     = in_last_reg | in_empty_reg;
    assign advance   = in_valid_reg && (!emits || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= rlc_pkg::MODE_NORMAL;
            in_valid_reg  <= 1'b0;
            running_reg   <= '0;
            first_reg     <= 1'b1;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= rlc_pkg::mode_t'(cfg_composition_mode);
            end
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                if (emits) begin
                    running_reg <= '0;
                    first_reg   <= 1'b1;
                    clip_reg    <= 1'b0;
                end else begin
                    running_reg <= fold_next;
                    first_reg   <= 1'b0;
                    clip_reg    <= clip_next;
                end
            end
            if (advance && emits) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_ratio_reg <= s_ratio;
            in_last_reg  <= s_last;
            in_empty_reg <= s_empty_req;
        end
        if (advance && emits) begin
            out_combined_reg  <= in_empty_reg ? '0 : final_val;
            out_saturated_reg <= !in_empty_reg && clip_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_combined  = out_combined_reg;
    assign m_saturated = out_saturated_reg;

    `RLC_ASSERT_NEXT(a_list_end_clears, aclk, aresetn, advance && emits,
        first_reg && !clip_reg && running_reg == '0, "list state not cleared after result")
    `RLC_ASSERT_NEXT(a_empty_gives_zero, aclk, aresetn, advance && in_empty_reg,
        m_valid && m_combined == '0 && !m_saturated, "empty list result not zero")
    `RLC_ASSERT_NEXT(a_normal_clamped, aclk, aresetn,
        advance && in_last_reg && mode_reg == rlc_pkg::MODE_NORMAL,
        m_combined <= RATIO_ONE && m_combined >= -RATIO_ONE, "normal result outside +-1.0")
    `RLC_ASSERT_NEXT(a_fold_clears_first, aclk, aresetn, advance && !emits,
        !first_reg, "first flag still set after a folded element")

endmodule

`default_nettype wire

// ===== dv/rlc_result_checker.sv =====
// ----------------------------------------------------------------------------
// rlc_result_checker
// Watches the mode, request and result channels of the ratio list combiner.
// Folds every accepted request into its own copy of the list state, queues
// the combined ratio each finished or empty list should give, and compares
// each result taken from the block against the oldest queued one.
// ----------------------------------------------------------------------------
module rlc_result_checker #(
    parameter int FRAC = 16,
    localparam int W = FRAC + 5
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [rlc_pkg::MODE_WIDTH-1:0] cfg_mode,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic signed [W-1:0]            s_ratio,
    input  logic                           s_last,
    input  logic                           s_empty_req,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic signed [W-1:0]            m_combined,
    input  logic                           m_saturated,
    output int                             error_count,
    output int                             results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_L = longint'(1) << FRAC;
    localparam longint MAX_L = (longint'(1) << (W - 1)) - 1;
    localparam longint MIN_L = -MAX_L - 1;
    localparam longint unsigned ROUND_HALF = longint'(1) << (FRAC - 1);
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [W-1:0] combined;
        logic                saturated;
    } list_result_t;

    logic [rlc_pkg::MODE_WIDTH-1:0] cur_mode;
    logic signed [W-1:0]   acc_value;
    bit                    first_elem;
    bit                    clip_flag;
    list_result_t          combined_q[$];

    function automatic longint clamp_to_range(input longint x);
        if (x > MAX_L) begin
            clip_flag = 1'b1;
            return MAX_L;
        end
        if (x < MIN_L) begin
            clip_flag = 1'b1;
            return MIN_L;
        end
        return x;
    endfunction

    // exact product, round half away from zero, then saturate
    function automatic longint mul_q_round(input longint a, input longint b);
        longint unsigned ma, mb, q, lim;
        bit neg;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        q = (ma * mb + ROUND_HALF) >> FRAC;
        lim = neg ? longint'(MAX_L + 1) : MAX_L;
        if (q > lim) begin
            clip_flag = 1'b1;
            return neg ? MIN_L : MAX_L;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic void clear_list();
        acc_value = '0;
        first_elem = 1'b1;
        clip_flag = 1'b0;
    endfunction

    function automatic bit fold_ratio(input logic signed [W-1:0] elem,
                                      input logic is_last, input logic is_empty,
                                      output list_result_t res);
        longint r, v, d, fin;
        r = longint'(elem);
        v = longint'(acc_value);
        res = '0;
        if (is_empty) begin
            clear_list();
            return 1'b1;
        end
        case (cur_mode)
            rlc_pkg::MODE_MAX: begin
                if (first_elem) v = -ONE_L;
                if (r > v) v = r;
            end
            rlc_pkg::MODE_MIN: begin
                if (first_elem) v = ONE_L;
                if (r < v) v = r;
            end
            rlc_pkg::MODE_SUM: begin
                if (first_elem) v = r;
                else v = clamp_to_range(v + r);
            end
            rlc_pkg::MODE_ABS_DIFF: begin
                if (first_elem) v = r;
                else begin
                    d = r - v;
                    v = clamp_to_range((d < 0) ? -d : d);
                end
            end
            rlc_pkg::MODE_DIFF: begin
                if (first_elem) v = r;
                else v = clamp_to_range(r - v);
            end
            rlc_pkg::MODE_PRODUCT: begin
                if (first_elem) v = r;
                else v = mul_q_round(v, r);
            end
            default: begin
                if (first_elem) v = 0;
                if (r >= 0 && v >= 0) v = (r > v) ? r : v;
                else if (r < 0 && v < 0) v = (r < v) ? r : v;
                else v = v + r;
            end
        endcase
        acc_value = v[W-1:0];
        first_elem = 1'b0;
        if (!is_last) return 1'b0;
        fin = v;
        if (cur_mode == rlc_pkg::MODE_NORMAL || cur_mode > rlc_pkg::MODE_PRODUCT) begin
            if (fin > ONE_L) fin = ONE_L;
            if (fin < -ONE_L) fin = -ONE_L;
        end
        res.combined = fin[W-1:0];
        res.saturated = clip_flag;
        clear_list();
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        list_result_t want, got;
        if (!aresetn) begin
            cur_mode = rlc_pkg::MODE_NORMAL;
            clear_list();
            combined_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                got.combined = m_combined;
                got.saturated = m_saturated;
                if (combined_q.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected result: combined %0d saturated %0b",
                                 $realtime, $signed(got.combined), got.saturated);
                end else begin
                    want = combined_q.pop_front();
                    if (got.combined !== want.combined ||
                        got.saturated !== want.saturated) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display({"%0t: mismatch: combined exp %0d got %0d, ",
                                      "saturated exp %0b got %0b"},
                                     $realtime, $signed(want.combined), $signed(got.combined),
                                     want.saturated, got.saturated);
                    end
                end
            end
            if (cfg_valid && cfg_ready) cur_mode = cfg_mode;
            if (s_valid && s_ready) begin
                if (fold_ratio(s_ratio, s_last, s_empty_req, want)) combined_q.push_back(want);
            end
        end
        results_pending = combined_q.size();
    end

endmodule

// ===== dv/tb_ratio_list_combiner_unit.sv =====
// ----------------------------------------------------------------------------
// tb_ratio_list_combiner_unit
// Drives the ratio list combiner with a directed set of lists covering every
// mode, the range limits, empty and cut lists, saturation, rounding and a
// mode change inside a list, then with random lists under several idle and
// stall patterns including a long receiver hold-off. Checking is done by
// rlc_result_checker; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_ratio_list_combiner_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = rlc_pkg::RATIO_FRAC_BITS_DEFAULT;
    localparam int W = FRAC + 5;
    localparam logic signed [W-1:0] R_ONE   = W'(1) << FRAC;
    localparam logic signed [W-1:0] R_HALF  = R_ONE >>> 1;
    localparam logic signed [W-1:0] R_THREE = W'(R_ONE * 3);
    localparam logic signed [W-1:0] R_MAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] R_MIN   = {1'b1, {(W-1){1'b0}}};
    localparam int ONE_INT = 1 << FRAC;

    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_HEAVY     = 85;
    localparam int IDLE_BOTH      = 21;
    localparam int PHASE_ITEMS    = 112;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [rlc_pkg::MODE_WIDTH-1:0] cfg_composition_mode;
    logic                  s_valid;
    logic                  s_ready;
    logic signed [W-1:0]   s_ratio;
    logic                  s_last;
    logic                  s_empty_req;
    logic                  m_valid;
    logic                  m_ready;
    logic signed [W-1:0]   m_combined;
    logic                  m_saturated;

    int error_count;
    int results_pending;
    int items_sent = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int quiet_cycles = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    always #10 aclk = ~aclk;

    ratio_list_combiner_unit #(.RATIO_FRAC_BITS(FRAC)) DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_composition_mode (cfg_composition_mode),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_ratio              (s_ratio),
        .s_last               (s_last),
        .s_empty_req          (s_empty_req),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_combined           (m_combined),
        .m_saturated          (m_saturated)
    );

    rlc_result_checker #(.FRAC(FRAC)) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_mode        (cfg_composition_mode),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ratio         (s_ratio),
        .s_last          (s_last),
        .s_empty_req     (s_empty_req),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_combined      (m_combined),
        .m_saturated     (m_saturated),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    // receiver; a long hold-off lets the block fill and stall its input
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_ratio_list_combiner_unit: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called and returns at a falling edge
    task automatic push_request(input logic signed [W-1:0] r, input logic l, input logic e);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_ratio <= r;
        s_last <= l;
        s_empty_req <= e;
        items_sent++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // mode is only changed with nothing in flight
    task automatic write_mode(input rlc_pkg::mode_t m);
        s_valid <= 1'b0;
        while (results_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_composition_mode <= m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [W-1:0] pick_ratio();
        int tmp;
        case ($urandom_range(9))
            0: return R_MAX;
            1: return R_MIN;
            2, 3: return W'($urandom);
            4: begin
                tmp = int'($urandom_range(510)) - 255;
                return W'(tmp);
            end
            default: begin
                tmp = int'($urandom_range(4 * ONE_INT)) - 2 * ONE_INT;
                return W'(tmp);
            end
        endcase
    endfunction

    // mostly well-formed lists; some empty, some cut short by an empty request
    task automatic send_list();
        int unsigned kind, len, k;
        kind = $urandom_range(99);
        if (kind < 7) begin
            push_request(pick_ratio(), 1'($urandom), 1'b1);
            return;
        end
        len = (kind < 90) ? $urandom_range(1, 4) : $urandom_range(5, 12);
        for (k = 0; k < len; k++) begin
            if ($urandom_range(99) < 3)
                write_mode(rlc_pkg::mode_t'($urandom_range(rlc_pkg::MODE_PRODUCT)));
            if (kind < 13 && k == len - 1) push_request(pick_ratio(), 1'($urandom), 1'b1);
            else push_request(pick_ratio(), k == len - 1, 1'b0);
        end
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct,
                             input rlc_pkg::mode_t start_mode, input bit long_hold);
        int target;
        target = items_sent + PHASE_ITEMS;
        write_mode(start_mode);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        if (long_hold) hold_req = 1'b1;
        while (items_sent < target) begin
            if ($urandom_range(4) == 0)
                write_mode(rlc_pkg::mode_t'($urandom_range(rlc_pkg::MODE_PRODUCT)));
            send_list();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_composition_mode = rlc_pkg::MODE_NORMAL;
        s_valid = 1'b0;
        s_ratio = '0;
        s_last = 1'b0;
        s_empty_req = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // normal mode from reset: empty, single clamped, mixed signs
        push_request(R_MAX, 1'b1, 1'b1);
        push_request(R_THREE, 1'b1, 1'b0);
        push_request(R_HALF, 1'b0, 1'b0);
        push_request(-(R_HALF + (R_HALF >>> 1)), 1'b0, 1'b0);
        push_request(R_MIN, 1'b1, 1'b0);

        write_mode(rlc_pkg::MODE_MAX);
        push_request(-R_THREE, 1'b1, 1'b0);
        push_request(R_MAX, 1'b0, 1'b0);
        push_request(R_MIN, 1'b0, 1'b1);

        write_mode(rlc_pkg::MODE_MIN);
        push_request(R_THREE, 1'b1, 1'b0);
        push_request(R_MIN, 1'b1, 1'b0);

        write_mode(rlc_pkg::MODE_SUM);
        push_request(R_MAX, 1'b0, 1'b0);
        push_request(R_MAX, 1'b1, 1'b0);

        write_mode(rlc_pkg::MODE_ABS_DIFF);
        push_request(R_MIN, 1'b0, 1'b0);
        push_request(R_MAX, 1'b1, 1'b0);

        write_mode(rlc_pkg::MODE_DIFF);
        push_request(R_MAX, 1'b0, 1'b0);
        push_request(R_MIN, 1'b1, 1'b0);

        // ties round away from zero
        write_mode(rlc_pkg::MODE_PRODUCT);
        push_request(W'(3), 1'b0, 1'b0);
        push_request(R_HALF, 1'b1, 1'b0);
        push_request(-W'(3), 1'b0, 1'b0);
        push_request(R_HALF, 1'b1, 1'b0);
        push_request(R_MIN, 1'b0, 1'b0);
        push_request(R_MIN, 1'b1, 1'b0);

        // mode switched between elements of one list
        write_mode(rlc_pkg::MODE_SUM);
        push_request(R_ONE, 1'b0, 1'b0);
        write_mode(rlc_pkg::MODE_PRODUCT);
        push_request(R_HALF, 1'b1, 1'b0);

        run_phase(0, 0, rlc_pkg::MODE_NORMAL, 1'b1);
        run_phase(IDLE_HEAVY, 0, rlc_pkg::MODE_PRODUCT, 1'b0);
        run_phase(0, IDLE_HEAVY, rlc_pkg::MODE_SUM, 1'b0);
        run_phase(IDLE_BOTH, IDLE_BOTH, rlc_pkg::MODE_ABS_DIFF, 1'b0);

        s_valid <= 1'b0;
        while (results_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0 && results_pending == 0) begin
            $display("tb_ratio_list_combiner_unit: done, clean");
        end else begin
            $display("tb_ratio_list_combiner_unit: done, errors");
        end
        $finish;
    end

endmodule
